### hdl/gps_pkg.sv
// Package for the down/right maze path search block.
// Sizes, codes and the controller/datapath command and status structs.
// No dependencies; used by every module of the block but gps_ram.
package gps_pkg;

    localparam int MAX_N       = 16;
    localparam int COORD_W     = $clog2(MAX_N);
    localparam int CMP_W       = COORD_W + 1;
    localparam int SIZE_W      = 5;
    localparam int N_W         = $clog2(MAX_N + 1);
    localparam int CELL_AW     = 2 * COORD_W;
    localparam int CELL_DEPTH  = 1 << CELL_AW;
    localparam int STACK_DEPTH = 2 * MAX_N - 1;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int STACK_W     = 2 * COORD_W + 1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

    // input command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SOLVE = 1'b1;

    // moves tried from the cell on top of the stack
    localparam logic [1:0] TRIED_NONE = 2'd0;
    localparam logic [1:0] TRIED_DOWN = 2'd1;
    localparam logic [1:0] TRIED_BOTH = 2'd2;

    typedef struct packed {
        logic maze_wr;
        logic solve_init;
        logic clr_step;
        logic seed;
        logic enter_start;
        logic try_move;
        logic push;
        logic mark_dead;
        logic pop_rd;
        logic pop_ld;
        logic out_load_path;
        logic out_load_none;
    } t_cmd;

    typedef struct packed {
        logic at_goal;
        logic tried_done;
        logic move_ok;
        logic cell_ok;
        logic sp_zero;
        logic k_at_top;
        logic clr_done;
        logic out_free;
    } t_status;

endpackage

### hdl/grid_path_search_down_right.sv
// Top level of the down/right maze path search.
// Depends on gps_pkg, gps_ctrl, gps_dp (and through it gps_ram).
//
// A write transaction (command 0) stores one maze cell, so cells load back to
// back. A solve transaction (command 1) first clears the dead-end marks with a
// pass over every cell of the 16x16 store, then checks the start cell, then
// runs the depth-first search one step at a time: each move tried into a cell
// inside the maze reads that cell before it is entered, a move that would leave
// the maze is skipped without a read, and each backtrack reads the parent back.
// Each cell is entered at most once per solve thanks to the dead-end marks.
// Results then leave one at a time, not back to back, each waiting while the
// output side is not ready. The block takes no new transaction while a solve
// runs; the output register lets the next one in as soon as the last result is loaded.
// The maze size register may be written at any time the block is idle.
module grid_path_search_down_right (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_command,
    input  logic [gps_pkg::COORD_W-1:0] i_row,
    input  logic [gps_pkg::COORD_W-1:0] i_col,
    input  logic                        i_cell_open,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_found,
    output logic [gps_pkg::COORD_W-1:0] o_path_row,
    output logic [gps_pkg::COORD_W-1:0] o_path_col,
    output logic                        o_last_of_path,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [gps_pkg::SIZE_W-1:0]  i_cfg_data
);

    gps_pkg::t_cmd    w_cmd;
    gps_pkg::t_status w_status;

    assign o_cfg_ready = 1'b1;

    gps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid && o_in_ready),
        .i_command  (i_command),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    gps_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_cell_open    (i_cell_open),
        .i_cfg_wr       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_found        (o_found),
        .o_path_row     (o_path_row),
        .o_path_col     (o_path_col),
        .o_last_of_path (o_last_of_path)
    );

endmodule

### hdl/gps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gps_ram #(
    parameter  int WIDTH = 1,
    parameter  int DEPTH = 2,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/gps_dp.sv
// Datapath of the maze path search: maze, dead-end and position stack RAMs,
// current cell, candidate move, counters and the output register.
// Depends on gps_pkg and gps_ram.
module gps_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gps_pkg::t_cmd                   i_cmd,
    output gps_pkg::t_status                o_status,
    input  logic [gps_pkg::COORD_W-1:0]     i_row,
    input  logic [gps_pkg::COORD_W-1:0]     i_col,
    input  logic                            i_cell_open,
    input  logic                            i_cfg_wr,
    input  logic [gps_pkg::SIZE_W-1:0]      i_cfg_data,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_found,
    output logic [gps_pkg::COORD_W-1:0]     o_path_row,
    output logic [gps_pkg::COORD_W-1:0]     o_path_col,
    output logic                            o_last_of_path
);

    localparam int CW  = gps_pkg::COORD_W;
    localparam int XW  = gps_pkg::CMP_W;
    localparam int SAW = gps_pkg::STACK_AW;
    localparam int CAW = gps_pkg::CELL_AW;
    localparam int SW  = gps_pkg::STACK_W;
    localparam int ZW  = gps_pkg::SIZE_W;

    logic [ZW-1:0]             r_maze_size;
    logic [gps_pkg::N_W-1:0]   r_n;
    logic [gps_pkg::N_W-1:0]   n_n;
    logic [CAW-1:0]            r_clr_cnt;
    logic [CW-1:0]             r_cur_r, r_cur_c;
    logic [1:0]                r_tried;
    logic [CW-1:0]             r_cand_r, r_cand_c;
    logic [SAW-1:0]            r_sp, r_k;
    logic                      r_out_valid, r_found, r_last;
    logic [CW-1:0]             r_prow, r_pcol;

    logic [XW-1:0]  w_next_r, w_next_c, w_n_x;
    logic           w_down;
    logic [CW-1:0]  w_cand_r, w_cand_c;
    logic           w_move_ok;

    logic           w_maze_wr_en, w_maze_rd, w_dead_rd;
    logic [CAW-1:0] w_maze_rd_addr;
    logic           w_dead_wr_en, w_dead_wr_data;
    logic [CAW-1:0] w_dead_wr_addr;
    logic [SAW-1:0] w_stk_rd_addr;
    logic [SW-1:0]  w_stk_wr_data, w_stk_rd;
    logic [CW-1:0]  w_stk_r, w_stk_c;
    logic           w_stk_both;
    logic           w_k_at_top;

    // size in use: zero counts as one, anything above MAX_N as MAX_N
    always_comb begin
        priority if (r_maze_size == '0) begin
            n_n = gps_pkg::N_W'(1);
        end else if ({1'b0, r_maze_size} > (ZW + 1)'(gps_pkg::MAX_N)) begin
            n_n = gps_pkg::N_W'(gps_pkg::MAX_N);
        end else begin
            n_n = gps_pkg::N_W'(r_maze_size);
        end
    end

    assign w_n_x    = XW'(r_n);
    assign w_next_r = {1'b0, r_cur_r} + XW'(1);
    assign w_next_c = {1'b0, r_cur_c} + XW'(1);
    assign w_down   = (r_tried == gps_pkg::TRIED_NONE);
    assign w_cand_r = w_down ? w_next_r[CW-1:0] : r_cur_r;
    assign w_cand_c = w_down ? r_cur_c : w_next_c[CW-1:0];
    assign w_move_ok = w_down ? (w_next_r < w_n_x) : (w_next_c < w_n_x);

    assign w_maze_wr_en   = i_cmd.maze_wr
                            && ({1'b0, i_row} < XW'(gps_pkg::MAX_N))
                            && ({1'b0, i_col} < XW'(gps_pkg::MAX_N));
    assign w_maze_rd_addr = i_cmd.seed ? '0 : {w_cand_r, w_cand_c};

    assign w_dead_wr_en   = i_cmd.clr_step || i_cmd.mark_dead;
    assign w_dead_wr_addr = i_cmd.mark_dead ? {r_cur_r, r_cur_c} : r_clr_cnt;
    assign w_dead_wr_data = i_cmd.mark_dead;

    assign w_stk_wr_data = {r_cur_r, r_cur_c, (r_tried == gps_pkg::TRIED_BOTH)};
    assign w_stk_rd_addr = i_cmd.pop_rd ? (r_sp - SAW'(1)) : r_k;
    assign w_stk_r       = w_stk_rd[SW-1 -: CW];
    assign w_stk_c       = w_stk_rd[CW:1];
    assign w_stk_both    = w_stk_rd[0];
    assign w_k_at_top    = (r_k == r_sp);

    gps_ram #(.WIDTH(1), .DEPTH(gps_pkg::CELL_DEPTH)) u_maze (
        .i_clk     (i_clk),
        .i_wr_en   (w_maze_wr_en),
        .i_wr_addr ({i_row, i_col}),
        .i_wr_data (i_cell_open),
        .i_rd_addr (w_maze_rd_addr),
        .o_rd_data (w_maze_rd)
    );

    gps_ram #(.WIDTH(1), .DEPTH(gps_pkg::CELL_DEPTH)) u_dead (
        .i_clk     (i_clk),
        .i_wr_en   (w_dead_wr_en),
        .i_wr_addr (w_dead_wr_addr),
        .i_wr_data (w_dead_wr_data),
        .i_rd_addr (w_maze_rd_addr),
        .o_rd_data (w_dead_rd)
    );

    gps_ram #(.WIDTH(SW), .DEPTH(gps_pkg::STACK_DEPTH)) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.push),
        .i_wr_addr (r_sp),
        .i_wr_data (w_stk_wr_data),
        .i_rd_addr (w_stk_rd_addr),
        .o_rd_data (w_stk_rd)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maze_size <= gps_pkg::SIZE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_maze_size <= i_cfg_data;
            end
            if (i_cmd.out_load_path || i_cmd.out_load_none) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // search registers; the top of the stack lives in r_cur_* and r_tried
    always_ff @(posedge i_clk) begin
        if (i_cmd.solve_init) begin
            r_n       <= n_n;
            r_clr_cnt <= '0;
            r_sp      <= '0;
            r_k       <= '0;
        end
        if (i_cmd.clr_step) begin
            r_clr_cnt <= r_clr_cnt + CAW'(1);
        end
        if (i_cmd.enter_start) begin
            r_cur_r <= '0;
            r_cur_c <= '0;
            r_tried <= gps_pkg::TRIED_NONE;
        end
        if (i_cmd.try_move) begin
            r_cand_r <= w_cand_r;
            r_cand_c <= w_cand_c;
            r_tried  <= w_down ? gps_pkg::TRIED_DOWN : gps_pkg::TRIED_BOTH;
        end
        if (i_cmd.push) begin
            r_sp    <= r_sp + SAW'(1);
            r_cur_r <= r_cand_r;
            r_cur_c <= r_cand_c;
            r_tried <= gps_pkg::TRIED_NONE;
        end
        if (i_cmd.pop_rd) begin
            r_sp <= r_sp - SAW'(1);
        end
        if (i_cmd.pop_ld) begin
            r_cur_r <= w_stk_r;
            r_cur_c <= w_stk_c;
            r_tried <= w_stk_both ? gps_pkg::TRIED_BOTH : gps_pkg::TRIED_DOWN;
        end
        if (i_cmd.out_load_path) begin
            r_found <= 1'b1;
            r_last  <= w_k_at_top;
            r_prow  <= w_k_at_top ? r_cur_r : w_stk_r;
            r_pcol  <= w_k_at_top ? r_cur_c : w_stk_c;
            r_k     <= r_k + SAW'(1);
        end
        if (i_cmd.out_load_none) begin
            r_found <= 1'b0;
            r_last  <= 1'b1;
            r_prow  <= '0;
            r_pcol  <= '0;
        end
    end

    always_comb begin
        o_status.at_goal    = (w_next_r == w_n_x) && (w_next_c == w_n_x);
        o_status.tried_done = (r_tried != gps_pkg::TRIED_NONE)
                              && (r_tried != gps_pkg::TRIED_DOWN);
        o_status.move_ok    = w_move_ok;
        o_status.cell_ok    = w_maze_rd && !w_dead_rd;
        o_status.sp_zero    = (r_sp == '0);
        o_status.k_at_top   = w_k_at_top;
        o_status.clr_done   = (r_clr_cnt == CAW'(gps_pkg::CELL_DEPTH - 1));
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_path_row     = r_prow;
    assign o_path_col     = r_pcol;
    assign o_last_of_path = r_last;

endmodule

### hdl/gps_ctrl.sv
// Controller of the maze path search: sequences load, dead-mark clear,
// depth-first search with backtracking and result emission.
// Depends on gps_pkg.
module gps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_command,
    output logic             o_in_ready,
    input  gps_pkg::t_status i_status,
    output gps_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SEED,
        S_SEED_CHK,
        S_SEARCH,
        S_CHECK,
        S_POP,
        S_EMIT_RD,
        S_EMIT_LD,
        S_NONE
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_command == gps_pkg::CMD_SOLVE) begin
                        o_cmd.solve_init = 1'b1;
                        n_state          = S_CLEAR;
                    end else begin
                        o_cmd.maze_wr = 1'b1;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_done) begin
                    n_state = S_SEED;
                end
            end
            S_SEED: begin
                o_cmd.seed = 1'b1;
                n_state    = S_SEED_CHK;
            end
            S_SEED_CHK: begin
                if (i_status.cell_ok) begin
                    o_cmd.enter_start = 1'b1;
                    n_state           = S_SEARCH;
                end else begin
                    n_state = S_NONE;
                end
            end
            S_SEARCH: begin
                priority if (i_status.at_goal) begin
                    n_state = S_EMIT_RD;
                end else if (!i_status.tried_done) begin
                    o_cmd.try_move = 1'b1;
                    if (i_status.move_ok) begin
                        n_state = S_CHECK;
                    end
                end else begin
                    // dead end: mark it and step back to the parent cell, or report no path at the start cell
                    o_cmd.mark_dead = 1'b1;
                    if (i_status.sp_zero) begin
                        n_state = S_NONE;
                    end else begin
                        o_cmd.pop_rd = 1'b1;
                        n_state      = S_POP;
                    end
                end
            end
            S_CHECK: begin
                o_cmd.push = i_status.cell_ok;
                n_state    = S_SEARCH;
            end
            S_POP: begin
                o_cmd.pop_ld = 1'b1;
                n_state      = S_SEARCH;
            end
            S_EMIT_RD: begin
                // stack read of the next path cell is under way
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (i_status.out_free) begin
                    o_cmd.out_load_path = 1'b1;
                    n_state = i_status.k_at_top ? S_IDLE : S_EMIT_RD;
                end
            end
            S_NONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load_none = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

### hdl/gps_checker.sv
// Port-level checks for the maze path search top level, with its bind.
// Depends on gps_pkg and grid_path_search_down_right.
module gps_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        i_command,
    input logic [gps_pkg::COORD_W-1:0] i_row,
    input logic [gps_pkg::COORD_W-1:0] i_col,
    input logic                        i_cell_open,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic                        o_found,
    input logic [gps_pkg::COORD_W-1:0] o_path_row,
    input logic [gps_pkg::COORD_W-1:0] o_path_col,
    input logic                        o_last_of_path,
    input logic                        i_cfg_valid,
    input logic                        o_cfg_ready,
    input logic [gps_pkg::SIZE_W-1:0]  i_cfg_data
);

    // nothing is offered straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_found)
            && $stable(o_path_row) && $stable(o_path_col) && $stable(o_last_of_path))
        else $error("stalled result changed");

    // a solve transaction closes the input straight after it is taken
    a_solve_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_command == gps_pkg::CMD_SOLVE) |=> !o_in_ready)
        else $error("input open right after a solve transaction");

    // a cell write never produces a result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_command == gps_pkg::CMD_WRITE) && !o_out_valid
            |=> !o_out_valid)
        else $error("result produced by a cell write");

    // the not-found result is the last of its solve and carries zero coordinates
    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_last_of_path && (o_path_row == '0)
            && (o_path_col == '0))
        else $error("malformed not-found result");

endmodule

bind grid_path_search_down_right gps_checker u_gps_checker (.*);
